// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted (active low)
`define TLS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tls assertion failed");

// overlapping implication built on the clocked property macro
`define TLS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  `TLS_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

// ===== hw/rtl/tls_pkg.sv =====
// shared types and constants of the text line splitter
`default_nettype none

package tls_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned KindW = 2;

  localparam logic [ByteW-1:0] CharCr = 8'd13;
  localparam logic [ByteW-1:0] CharLf = 8'd10;

  localparam logic [LenW-1:0] MaxLineReset = 16'd256;

  localparam int unsigned FifoDepthDef = 4;

  // input word type (tuser)
  localparam logic ReqByte = 1'b0;
  localparam logic ReqEnd  = 1'b1;

  typedef enum logic [KindW-1:0] {
    KindData = 2'd0,
    KindLine = 2'd1,
    KindCut  = 2'd2,
    KindEnd  = 2'd3
  } kind_e;

  // one decoded input item: an optional closing word then an optional tail word
  typedef struct packed {
    logic             has_close;
    kind_e            close_kind;
    logic [LenW-1:0]  close_len;
    logic             has_tail;
    kind_e            tail_kind;
    logic [ByteW-1:0] tail_byte;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tls_front.sv =====
// front end: takes input words, tracks line state, builds queue entries
`default_nettype none

module tls_front import tls_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LenW-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  input  wire logic             in_req_i,
  input  wire logic [ByteW-1:0] in_byte_i,
  output logic                  in_ready_o,
  input  wire logic             fifo_full_i,
  output logic                  push_o,
  output entry_t                push_entry_o
);

  logic [LenW-1:0] max_q;
  logic [LenW-1:0] count_q, count_d;
  logic            cr_q, cr_d;
  logic [LenW-1:0] max_eff;
  logic            accept;
  logic            produce;
  entry_t          entry;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign max_eff    = (max_q == '0) ? LenW'(1) : max_q;

  always_comb begin
    entry   = '0;
    produce = 1'b1;
    count_d = count_q;
    cr_d    = 1'b0;
    if (in_req_i == ReqEnd) begin
      entry.has_close  = (count_q != '0);
      entry.close_kind = KindLine;
      entry.close_len  = count_q;
      entry.has_tail   = 1'b1;
      entry.tail_kind  = KindEnd;
      count_d          = '0;
    end else if (in_byte_i == CharCr) begin
      entry.has_close  = 1'b1;
      entry.close_kind = KindLine;
      entry.close_len  = count_q;
      count_d          = '0;
      cr_d             = 1'b1;
    end else if (in_byte_i == CharLf) begin
      // lf right after cr is swallowed
      produce          = !cr_q;
      entry.has_close  = 1'b1;
      entry.close_kind = KindLine;
      entry.close_len  = count_q;
      if (!cr_q) begin
        count_d = '0;
      end
    end else begin
      entry.has_tail  = 1'b1;
      entry.tail_kind = KindData;
      entry.tail_byte = in_byte_i;
      if (count_q >= max_eff) begin
        entry.has_close  = 1'b1;
        entry.close_kind = KindCut;
        entry.close_len  = count_q;
        count_d          = LenW'(1);
      end else begin
        count_d = count_q + LenW'(1);
      end
    end
  end

  assign push_o       = accept && produce;
  assign push_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= MaxLineReset;
      count_q <= '0;
      cr_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
        cr_q    <= cr_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tls_fifo.sv =====
// small register queue between front and back
`default_nettype none

module tls_fifo import tls_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t push_entry_i,
  input  wire logic   pop_i,
  output entry_t      head_o,
  output logic        empty_o,
  output logic        full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tls_back.sv =====
// back end: expands queue entries into output words through an output register
`default_nettype none

module tls_back import tls_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire entry_t            head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output kind_e                  out_kind_o,
  output logic [ByteW-1:0]       out_byte_o,
  output logic [LenW-1:0]        out_len_o,
  output logic                   out_last_o
);

  logic             valid_q, valid_d;
  logic             phase_q, phase_d;
  logic             load;
  logic             send_close;
  kind_e            kind_q, kind_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             last_q, last_d;

  assign load       = !valid_q || out_ready_i;
  // closing word of the head entry not yet sent
  assign send_close = head_i.has_close && !phase_q;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    pop_o   = 1'b0;
    kind_d  = send_close ? head_i.close_kind : head_i.tail_kind;
    byte_d  = send_close ? '0 : head_i.tail_byte;
    len_d   = send_close ? head_i.close_len : '0;
    last_d  = send_close ? !head_i.has_tail : 1'b1;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        phase_d = send_close && head_i.has_tail;
        pop_o   = !(send_close && head_i.has_tail);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      len_q  <= len_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;
  assign out_len_o   = len_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/text_line_splitter_unit.sv =====
// top level of the text line splitter: front end, queue and back end
// an accepted word is written into the queue, then into the output register
// throughput: one input word per cycle while the queue is not full; the output register
//   sends one word a cycle while the receiver is ready, so items that give two words
//   (cut plus byte, line plus end) send them in turn; a swallowed lf after cr gives no output
// reset (rst_ni low, async) empties the queue, clears line state, max length to 256
`default_nettype none

module text_line_splitter_unit import tls_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration: max line bytes
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,
  // input stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic         s_axis_tuser_i,   // [0] req_type
  // output stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,   // [7:0] data_byte, [23:8] line_length
  output logic [1:0]        m_axis_tuser_o,   // [1:0] kind
  output logic              m_axis_tlast_o    // last word of an input item
);

  // queue handshake between front and back
  entry_t push_entry;
  entry_t head;
  logic   push, pop;
  logic   fifo_full, fifo_empty;

  // back end word fields
  kind_e            out_kind;
  logic [ByteW-1:0] out_byte;
  logic [LenW-1:0]  out_len;

  // front: classifies each byte and updates the running line count
  tls_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_req_i     (s_axis_tuser_i),
    .in_byte_i    (s_axis_tdata_i),
    .in_ready_o   (s_axis_tready_o),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // short queue decouples input acceptance from output stalls
  tls_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (fifo_empty),
    .full_o       (fifo_full)
  );

  // back: one or two output words per entry
  tls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (out_kind),
    .out_byte_o  (out_byte),
    .out_len_o   (out_len),
    .out_last_o  (m_axis_tlast_o)
  );

  // pack the output word, data byte in the low bits
  assign m_axis_tdata_o = {out_len, out_byte};
  assign m_axis_tuser_o = out_kind;

endmodule

`default_nettype wire

// ===== hw/rtl/tls_checker.sv =====
// port level checks of the text line splitter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module tls_checker import tls_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  logic        out_word;
  logic        out_stall;
  logic [26:0] out_bits;
  logic        fields_ok;

  assign out_word  = m_axis_tvalid_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_bits  = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};
  // data words carry no length, other words carry no byte
  assign fields_ok = (m_axis_tuser_o == KindData) ? (m_axis_tdata_o[23:8] == 16'd0)
                                                  : (m_axis_tdata_o[7:0] == 8'd0);

  // a stalled output word holds
  `TLS_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> (m_axis_tvalid_o && $stable(out_bits)))

  // end marker always closes its item
  `TLS_ASSERT_IMPL(a_end_last, clk_i, rst_ni, out_word && (m_axis_tuser_o == KindEnd), m_axis_tlast_o)

  // a cut is always followed by the byte that caused it
  `TLS_ASSERT_IMPL(a_cut_not_last, clk_i, rst_ni, out_word && (m_axis_tuser_o == KindCut), !m_axis_tlast_o)

  // field contents match the word kind
  `TLS_ASSERT_IMPL(a_data_fields, clk_i, rst_ni, out_word, fields_ok)

endmodule

bind text_line_splitter_unit tls_checker u_tls_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for text_line_splitter_unit: line framing, cuts, end markers
`default_nettype none

module testbench;
  import tls_pkg::*;

  localparam int HoldCycles  = 200;   // long receiver hold-off in the pressure test
  localparam int DrainLimit  = 1000;  // cycles to wait for outstanding words
  localparam int WatchLimit  = 4000;  // cycles with no handshake before giving up
  localparam int PrintLimit  = 40;    // cap on mismatch lines

  // one expected output word
  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  len;
    logic             last;
  } out_word_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [15:0]      cfg_wdata = 16'd0;
  logic             in_valid  = 1'b0;
  logic [7:0]       in_byte   = 8'd0;
  logic             in_req    = ReqByte;
  logic             out_ready = 1'b0;

  wire              s_axis_tready_o;
  wire              m_axis_tvalid_o;
  wire [23:0]       m_axis_tdata_o;
  wire [1:0]        m_axis_tuser_o;
  wire              m_axis_tlast_o;

  // line framing state mirrored from the block
  logic [LenW-1:0]  max_len   = MaxLineReset;
  logic [LenW-1:0]  piece_len = '0;
  logic             cr_seen   = 1'b0;
  out_word_t        words_due[$];

  // stimulus knobs
  bit tx_gaps   = 1'b0;
  bit rx_stalls = 1'b0;
  bit sink_hold = 1'b0;

  int errors        = 0;
  int items_sent    = 0;
  int words_checked = 0;
  int cuts_due      = 0;
  int limits_used   = 1;
  int quiet         = 0;

  text_line_splitter_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_byte),
    .s_axis_tuser_i  (in_req),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // line framing prediction: computes the words one input word causes
  // ---------------------------------------------------------------------------
  function automatic void frame_word(input logic req, input logic [7:0] b);
    out_word_t       w[$];
    logic [LenW-1:0] limit;
    limit = (max_len == '0) ? 16'd1 : max_len;   // a zero limit acts as one
    if (req == ReqEnd) begin
      // close a pending partial line, never one already ended by cr or lf
      if (piece_len != '0) w.push_back('{KindLine, 8'd0, piece_len, 1'b0});
      w.push_back('{KindEnd, 8'd0, 16'd0, 1'b0});
      piece_len = '0;
      cr_seen   = 1'b0;
    end else if (b == CharCr) begin
      w.push_back('{KindLine, 8'd0, piece_len, 1'b0});
      piece_len = '0;
      cr_seen   = 1'b1;
    end else if (b == CharLf) begin
      // lf right after cr is swallowed
      if (!cr_seen) begin
        w.push_back('{KindLine, 8'd0, piece_len, 1'b0});
        piece_len = '0;
      end
      cr_seen = 1'b0;
    end else begin
      if (piece_len >= limit) begin
        w.push_back('{KindCut, 8'd0, piece_len, 1'b0});
        piece_len = '0;
        cuts_due++;
      end
      w.push_back('{KindData, b, 16'd0, 1'b0});
      piece_len = piece_len + 16'd1;
      cr_seen   = 1'b0;
    end
    if (w.size() > 0) w[w.size()-1].last = 1'b1;
    foreach (w[i]) words_due.push_back(w[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // any byte that is not a line terminator
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CharCr || b == CharLf) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // terminator-heavy noise
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return CharCr;
      1: return CharLf;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // line lengths cluster around the limit; big limits keep lines short
  function automatic int pick_len();
    int cap;
    cap = (max_len == '0) ? 1 : int'(max_len);
    if (cap > 48) return $urandom_range(0, 40);
    case ($urandom_range(0, 3))
      0: return cap;
      1: return cap + 1;
      2: return $urandom_range(0, cap);
      default: return $urandom_range(0, 3 * cap + 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver side
  // ---------------------------------------------------------------------------
  // offers one word and waits for the handshake; valid stays high between
  // back-to-back words and drops only for a gap
  task automatic push_word(input logic req, input logic [7:0] b);
    int idle;
    idle = 0;
    if (tx_gaps && $urandom_range(0, 3) == 0) idle = gap_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_req   <= req;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    frame_word(req, b);
    items_sent++;
  endtask

  // plain bytes followed by a random terminator, or none at all
  task automatic send_line(input int len);
    int i;
    for (i = 0; i < len; i++) push_word(ReqByte, plain_byte());
    case ($urandom_range(0, 9))
      0, 1, 2: push_word(ReqByte, CharCr);
      3, 4, 5: push_word(ReqByte, CharLf);
      6, 7: begin
        push_word(ReqByte, CharCr);
        push_word(ReqByte, CharLf);
      end
      8: push_word(ReqEnd, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // stops the input and waits for every expected word, then idles on
  // so that a trailing swallowed lf has left the block too
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (words_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (words_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never came out", $realtime, words_due.size());
      words_due.delete();
    end
  endtask

  // register write, only ever called with the block idle
  task automatic set_max_len(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    max_len = v;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink_side
    int idle;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        sink_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
        idle = gap_len();
        out_ready <= 1'b0;
        repeat (idle) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output check: every accepted word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_check
    out_word_t want;
    out_word_t got;
    if (rst_n && m_axis_tvalid_o && out_ready) begin
      got.kind = kind_e'(m_axis_tuser_o);
      got.data = m_axis_tdata_o[7:0];
      got.len  = m_axis_tdata_o[23:8];
      got.last = m_axis_tlast_o;
      words_checked++;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= PrintLimit)
          $display("%0t: unexpected word kind=%0d data=%02h len=%0d last=%0b",
                   $realtime, got.kind, got.data, got.len, got.last);
      end else begin
        want = words_due.pop_front();
        if (got.kind !== want.kind || got.data !== want.data ||
            got.len !== want.len || got.last !== want.last) begin
          errors++;
          if (errors <= PrintLimit)
            $display("%0t: expected kind=%0d data=%02h len=%0d last=%0b, got kind=%0d data=%02h len=%0d last=%0b",
                     $realtime, want.kind, want.data, want.len, want.last,
                     got.kind, got.data, got.len, got.last);
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if ((in_valid && s_axis_tready_o) || (m_axis_tvalid_o && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= WatchLimit) begin
      $display("%0t: no handshake for %0d cycles", $realtime, WatchLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset limit of 256: an over-long line is cut, one exactly at the limit is not
  task automatic test_reset_limit();
    int i;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    for (i = 0; i < 300; i++) push_word(ReqByte, plain_byte());
    push_word(ReqByte, CharCr);
    push_word(ReqByte, CharLf);
    for (i = 0; i < 256; i++) push_word(ReqByte, plain_byte());
    push_word(ReqByte, CharLf);
    push_word(ReqEnd, 8'h00);
    settle();
  endtask

  // hand-picked corner cases at a tiny limit, then the zero limit
  task automatic test_directed_cases();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    set_max_len(16'd3);
    limits_used++;
    push_word(ReqByte, CharLf);      // lone lf: empty line
    push_word(ReqByte, CharCr);      // lone cr: empty line
    push_word(ReqByte, CharLf);      // lf of cr-lf swallowed
    push_word(ReqByte, 8'h00);       // zero is a plain byte
    push_word(ReqByte, 8'hFF);
    push_word(ReqByte, 8'h62);
    push_word(ReqByte, 8'h63);       // fourth byte: cut, then opens next piece
    push_word(ReqByte, CharCr);
    push_word(ReqByte, CharLf);
    push_word(ReqByte, CharCr);      // cr cr: two empty lines
    push_word(ReqByte, CharCr);
    push_word(ReqByte, 8'h41);
    push_word(ReqEnd, 8'hFF);        // end closes the partial line
    push_word(ReqEnd, 8'h00);        // end with nothing pending
    push_word(ReqByte, CharCr);
    push_word(ReqEnd, 8'h5A);        // line already ended: end marker only
    push_word(ReqByte, CharLf);      // end cleared the cr flag
    push_word(ReqByte, 8'h01);
    push_word(ReqByte, 8'h02);
    push_word(ReqByte, 8'h03);
    push_word(ReqByte, 8'h00);       // zero byte opening a piece after a cut
    settle();
    set_max_len(16'd0);              // behaves as a limit of one
    limits_used++;
    push_word(ReqByte, 8'h78);
    push_word(ReqByte, 8'h79);
    push_word(ReqEnd, 8'h00);
    settle();
  endtask

  // one random phase at a given limit: mostly framed lines, some noise
  task automatic run_random_phase(input logic [15:0] limit, input int goal);
    int stop;
    int r;
    int n;
    int i;
    set_max_len(limit);
    limits_used++;
    stop = items_sent + goal;
    while (items_sent < stop) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_line(pick_len());
      end else if (r < 9) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) push_word(ReqByte, noise_byte());
      end else begin
        push_word(ReqEnd, 8'($urandom_range(0, 255)));
      end
    end
    settle();
  endtask

  // random traffic over several limits, the extremes among them, with the
  // idle pattern rotating so some phases run with no gaps at all
  task automatic test_random_limits();
    logic [15:0] limits[8];
    int k;
    limits = '{16'd1, 16'd2, 16'd7, 16'd16, 16'hFFFF, 16'd0,
               16'($urandom_range(3, 30)), 16'd5};
    for (k = 0; k < 8; k++) begin
      tx_gaps   = (k % 4 == 0) || (k % 4 == 1);
      rx_stalls = (k % 4 == 0) || (k % 4 == 2);
      run_random_phase(limits[k], 140);
    end
  endtask

  // receiver holds off long while the sender keeps going, so the block
  // fills up and has to stall its input
  task automatic test_output_hold_off();
    int i;
    set_max_len(16'd5);
    limits_used++;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    sink_hold = 1'b1;
    for (i = 0; i < 60; i++) push_word(ReqByte, plain_byte());
    push_word(ReqEnd, 8'h00);
    settle();
  endtask

  initial begin : main
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_limit();
    test_directed_cases();
    test_random_limits();
    test_output_hold_off();
    in_valid <= 1'b0;
    repeat (10) @(posedge clk);
    if (words_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words left over", $realtime, words_due.size());
    end
    $display("stimulus: %0d input words over %0d limit settings, including cuts, cr-lf pairs",
             items_sent, limits_used);
    $display("checked %0d output words (%0d line cuts), %0d errors",
             words_checked, cuts_due, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== text_line_splitter_unit.f =====
+incdir+hw/rtl
hw/rtl/tls_pkg.sv
hw/rtl/tls_front.sv
hw/rtl/tls_fifo.sv
hw/rtl/tls_back.sv
hw/rtl/text_line_splitter_unit.sv
hw/rtl/tls_checker.sv
bench/testbench.sv
